FILE: hw/rtl/spl_pkg.sv
package spl_pkg;

    // register map of the configuration port
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 2'd2;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;   // one-cycle pulse, result valid from this cycle on
    } t_unit_sts;

endpackage

FILE: hw/rtl/stereo_peak_limiter.sv
// Stereo peak limiter. Each input transfer carries a left/right sample pair (signed Q1.F,
// F = SAMPLE_BITS-1); each output transfer carries both samples scaled by the gain envelope
// and clamped to +/- ceiling, plus the gain applied. When the larger sample magnitude
// exceeds the threshold the envelope drops at once to min(envelope, threshold/peak);
// otherwise it recovers towards unity by release_coeff of the remaining distance.
// All products and the quotient are floored. Each pair runs through the bit-serial divider
// on attack or the release multiplier on release, then through the two bit-serial gain
// multipliers, one per channel. A finished result sits in the output register, so the next
// pair can be taken while it waits.
module stereo_peak_limiter #(
    parameter  int SAMPLE_BITS = 24,
    localparam int IN_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W       = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_cfg_we,
    input  logic [spl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [SAMPLE_BITS-1:0]         i_cfg_data,

    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [IN_W-1:0]                s_axis_tdata,   // left_in, right_in

    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [OUT_W-1:0]               m_axis_tdata    // left_out, right_out, gain_now
);

    localparam int W = SAMPLE_BITS;
    localparam int F = SAMPLE_BITS - 1;

    localparam logic [W-1:0] UNITY = {1'b1, {F{1'b0}}};
    localparam logic [W-1:0] COEFF_RESET = W'(8192);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ENV    = 3'd1;
    localparam logic [2:0] S_GSTART = 3'd2;
    localparam logic [2:0] S_GAIN   = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] s);
        f_mag = s[W-1] ? (~s + W'(1)) : s;
    endfunction

    // truncate (floor) the product, clamp to ceiling, restore the sign
    function automatic logic [W-1:0] f_finish(input logic [2*W-1:0] p, input logic neg,
                                              input logic [F-1:0] ceil);
        logic [W:0]   m;
        logic [W-1:0] mc;
        m  = {1'b0, p[F+W-1:F]} + (W+1)'(neg && (|p[F-1:0]));
        mc = (m > {2'b00, ceil}) ? {1'b0, ceil} : m[W-1:0];
        f_finish = neg ? (~mc + W'(1)) : mc;
    endfunction

    // configuration
    logic [F-1:0] r_thr;
    logic [F-1:0] r_ceil;
    logic [W-1:0] r_coeff;

    // control
    logic [2:0]   r_state;
    logic         r_attack;
    logic [W-1:0] r_env;
    logic         r_m_valid;

    // per-pair payload
    logic [W-1:0] r_mag_l;
    logic [W-1:0] r_mag_r;
    logic         r_neg_l;
    logic         r_neg_r;
    logic [W-1:0] r_out_l;
    logic [W-1:0] r_out_r;
    logic [W-1:0] r_out_g;

    logic [W-1:0]   in_left;
    logic [W-1:0]   in_right;
    logic [W-1:0]   mag_l;
    logic [W-1:0]   mag_r;
    logic [W-1:0]   peak;
    logic           attack;
    logic [W-1:0]   c_sat;
    logic [W-1:0]   env0;
    logic [W:0]     rel_sum;
    logic [W-1:0]   env_rel;
    logic [W-1:0]   env_att;
    logic           s_fire;
    logic           out_load;

    logic           div_start;
    logic           mul0_start;
    logic           gain_start;
    logic [W-1:0]   mul0_a;
    logic [W-1:0]   mul0_b;
    logic [W-1:0]   div_quo;
    logic [2*W-1:0] mul0_prod;
    logic [2*W-1:0] mul1_prod;

    spl_pkg::t_unit_sts div_sts;
    spl_pkg::t_unit_sts mul0_sts;
    spl_pkg::t_unit_sts mul1_sts;

    always_comb begin
        in_left    = s_axis_tdata[W-1:0];
        in_right   = s_axis_tdata[2*W-1:W];
        mag_l      = f_mag(in_left);
        mag_r      = f_mag(in_right);
        peak       = (mag_l > mag_r) ? mag_l : mag_r;
        attack     = (peak > {1'b0, r_thr});

        c_sat      = (r_coeff > UNITY) ? UNITY : r_coeff;
        env0       = (r_env > UNITY) ? UNITY : r_env;
        rel_sum    = {1'b0, env0} + {1'b0, mul0_prod[F+W-1:F]};
        env_rel    = (rel_sum > {1'b0, UNITY}) ? UNITY : rel_sum[W-1:0];
        env_att    = (div_quo < r_env) ? div_quo : r_env;

        s_fire     = s_axis_tvalid && s_axis_tready;
        gain_start = (r_state == S_GSTART);
        div_start  = s_fire && attack;
        mul0_start = (s_fire && !attack) || gain_start;
        // unit 0 serves the release step first, then the left channel
        mul0_a     = gain_start ? r_mag_l : (UNITY - env0);
        mul0_b     = gain_start ? r_env : c_sat;

        out_load   = (r_state == S_FIN) && (!r_m_valid || m_axis_tready);
    end

    spl_div #(.WIDTH(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({1'b0, r_thr}),
        .i_den   (peak),
        .o_sts   (div_sts),
        .o_quo   (div_quo)
    );

    spl_mul #(.WIDTH(W)) u_mul0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul0_start),
        .i_a     (mul0_a),
        .i_b     (mul0_b),
        .o_sts   (mul0_sts),
        .o_prod  (mul0_prod)
    );

    spl_mul #(.WIDTH(W)) u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gain_start),
        .i_a     (r_mag_r),
        .i_b     (r_env),
        .o_sts   (mul1_sts),
        .o_prod  (mul1_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= {F{1'b1}};
            r_ceil  <= {F{1'b1}};
            r_coeff <= COEFF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                spl_pkg::REG_THRESHOLD: r_thr   <= i_cfg_data[F-1:0];
                spl_pkg::REG_CEILING:   r_ceil  <= i_cfg_data[F-1:0];
                spl_pkg::REG_RELEASE:   r_coeff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_attack  <= 1'b0;
            r_env     <= UNITY;
            r_m_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_fire) begin
                        r_attack <= attack;
                        r_state  <= S_ENV;
                    end
                end
                S_ENV: begin
                    if (r_attack && div_sts.done) begin
                        r_env   <= env_att;
                        r_state <= S_GSTART;
                    end else if (!r_attack && mul0_sts.done) begin
                        r_env   <= env_rel;
                        r_state <= S_GSTART;
                    end
                end
                S_GSTART: r_state <= S_GAIN;
                S_GAIN: begin
                    if (mul0_sts.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_mag_l <= mag_l;
            r_mag_r <= mag_r;
            r_neg_l <= in_left[W-1];
            r_neg_r <= in_right[W-1];
        end
        if (out_load) begin
            r_out_l <= f_finish(mul0_prod, r_neg_l, r_ceil);
            r_out_r <= f_finish(mul1_prod, r_neg_r, r_ceil);
            r_out_g <= r_env;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_W'({r_out_g, r_out_r, r_out_l});

`ifndef SYNTHESIS
    a_env_le_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env <= UNITY)
        else $error("gain envelope above unity");

    a_unit_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> (div_sts.busy || mul0_sts.busy))
        else $error("no arithmetic unit started on an accepted pair");

    a_gain_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GAIN && mul0_sts.done) |-> mul1_sts.done)
        else $error("channel multipliers out of step");
`endif

endmodule

FILE: hw/rtl/spl_mul.sv
// Unsigned shift-add multiplier, one multiplier bit per cycle, LSB first.
module spl_mul #(
    parameter int WIDTH = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WIDTH-1:0]     i_a,
    input  logic [WIDTH-1:0]     i_b,
    output spl_pkg::t_unit_sts   o_sts,
    output logic [2*WIDTH-1:0]   o_prod
);

    localparam int CW = $clog2(WIDTH);

    logic [2*WIDTH-1:0] r_acc;
    logic [WIDTH-1:0]   r_a;
    logic [WIDTH-1:0]   r_b;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [WIDTH:0]     n_sum;
    logic [2*WIDTH-1:0] n_acc;

    always_comb begin
        n_sum = {1'b0, r_acc[2*WIDTH-1:WIDTH]} + (r_b[0] ? {1'b0, r_a} : '0);
        n_acc = {n_sum, r_acc[WIDTH-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= r_b >> 1;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc;

endmodule

FILE: hw/rtl/spl_div.sv
// Restoring divider, one quotient bit per cycle.
// Returns floor(num * 2^(WIDTH-1) / den); needs num < den <= 2^(WIDTH-1).
module spl_div #(
    parameter int WIDTH = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [WIDTH-1:0]   i_num,
    input  logic [WIDTH-1:0]   i_den,
    output spl_pkg::t_unit_sts o_sts,
    output logic [WIDTH-1:0]   o_quo
);

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_den;
    logic [WIDTH-1:0] r_quo;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH-1:0] n_shift;
    logic             n_ge;

    // rem < den <= 2^(WIDTH-1), so the doubled remainder still fits
    always_comb begin
        n_shift = {r_rem[WIDTH-2:0], 1'b0};
        n_ge    = (n_shift >= r_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH - 2);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? (n_shift - r_den) : n_shift;
            r_quo <= {r_quo[WIDTH-2:0], n_ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;

endmodule

FILE: test/stereo_peak_limiter_tb.sv
`timescale 1ns / 100ps

module stereo_peak_limiter_tb;

    localparam int                                SAMPLE_BITS = 24;
    localparam int                                FRAC_BITS   = SAMPLE_BITS - 1;
    localparam longint unsigned                   UNITY       = 64'd1 << FRAC_BITS;
    localparam longint unsigned                   FRAC_MASK   = UNITY - 1;
    localparam logic [spl_pkg::CFG_IDX_W-1:0]     REG_SPARE   = 2'd3;   // not decoded by the block
    localparam int                                CYCLE_LIMIT = 800000;
    localparam int                                HOLD_AT     = 80;
    localparam int                                HOLD_CYCLES = 500;
    localparam int                                TAIL_CYCLES = 60;

    logic                            i_clk;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_we      = 1'b0;
    logic [spl_pkg::CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [SAMPLE_BITS-1:0]          i_cfg_data    = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [47:0]                     s_axis_tdata  = '0;   // left_in, right_in
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [71:0]                     m_axis_tdata;         // left_out, right_out, gain_now

    int snd_idle_pct = 36;
    int rcv_idle_pct = 68;
    int n_sent       = 0;
    int hold_left    = 0;
    bit held_once    = 1'b0;
    int cycles       = 0;

    stereo_peak_limiter #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    class limiter_scoreboard;
        logic [22:0] thr;
        logic [22:0] ceiling;
        logic [23:0] rel;
        logic [23:0] env;
        logic [71:0] limited_q[$];
        int          errors;

        function new();
            thr     = '1;
            ceiling = '1;
            rel     = 24'd8192;
            env     = 24'h800000;
            errors  = 0;
        endfunction

        function void write_reg(logic [spl_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
            case (idx)
                spl_pkg::REG_THRESHOLD: thr = val[22:0];
                spl_pkg::REG_CEILING:   ceiling = val[22:0];
                spl_pkg::REG_RELEASE:   rel = val;
                default: ;
            endcase
        endfunction

        // sample times gain, floored, then clamped to +/- ceiling
        function logic [23:0] scale(longint s, longint unsigned gain);
            longint unsigned p;
            longint          r;
            longint          c;
            c = longint'(ceiling);
            p = (s < 0 ? -s : s);
            p = p * gain;
            if (s >= 0) begin
                r = p >> FRAC_BITS;
            end else begin
                r = (p + FRAC_MASK) >> FRAC_BITS;
                r = -r;
            end
            if (r > c) r = c;
            if (r < -c) r = -c;
            return r[23:0];
        endfunction

        function void limit_pair(logic [47:0] d);
            longint          sl;
            longint          sr;
            longint unsigned ml;
            longint unsigned mr;
            longint unsigned peak;
            longint unsigned target;
            longint unsigned c;
            longint unsigned e;
            sl   = longint'($signed(d[23:0]));
            sr   = longint'($signed(d[47:24]));
            ml   = (sl < 0) ? -sl : sl;
            mr   = (sr < 0) ? -sr : sr;
            peak = (ml > mr) ? ml : mr;
            if (peak > thr) begin
                target = 64'(thr);
                target = (target << FRAC_BITS) / peak;
                if (target < env) env = target[23:0];
            end else begin
                c = (rel > UNITY) ? UNITY : rel;
                e = (env > UNITY) ? UNITY : env;
                e = e + (((UNITY - e) * c) >> FRAC_BITS);
                if (e > UNITY) e = UNITY;
                env = e[23:0];
            end
            limited_q.push_back({env, scale(sr, 64'(env)), scale(sl, 64'(env))});
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_output(logic [71:0] d);
            logic [71:0] want;
            if (limited_q.size() == 0) begin
                report($sformatf("unexpected output transfer %h", d));
            end else begin
                want = limited_q.pop_front();
                if (d[23:0] !== want[23:0])
                    report($sformatf("left_out %h, want %h", d[23:0], want[23:0]));
                if (d[47:24] !== want[47:24])
                    report($sformatf("right_out %h, want %h", d[47:24], want[47:24]));
                if (d[71:48] !== want[71:48])
                    report($sformatf("gain_now %h, want %h", d[71:48], want[71:48]));
            end
        endtask
    endclass

    limiter_scoreboard sb;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** stereo_peak_limiter: FAILED **");
            $finish;
        end
    end

    // transfer monitors
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.limit_pair(s_axis_tdata);
                n_sent <= n_sent + 1;
            end
            if (m_axis_tvalid && m_axis_tready)
                sb.check_output(m_axis_tdata);
        end
    end

    // sink: random back-pressure, one long hold so the input side stalls
    always @(posedge i_clk) begin
        if (!held_once && n_sent == HOLD_AT) begin
            held_once     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task send_pair(logic [23:0] left, logic [23:0] right);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.limited_q.size() != 0) @(posedge i_clk);
    endtask

    task write_reg(logic [spl_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task apply_config(logic [23:0] thr, logic [23:0] ceiling, logic [23:0] rel,
                      bit poke_spare);
        write_reg(spl_pkg::REG_THRESHOLD, thr);
        write_reg(spl_pkg::REG_CEILING, ceiling);
        write_reg(spl_pkg::REG_RELEASE, rel);
        if (poke_spare) write_reg(REG_SPARE, 24'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] pick_level(bit is_release);
        case ($urandom_range(3))
            0: return is_release ? 24'd0 : 24'd1;
            1: return is_release ? 24'h800000 : 24'h7FFFFF;
            2: return is_release ? 24'($urandom_range(65535)) :
                                   24'($urandom_range(24'h7FFFFF, 1));
            // top bit is outside the 23-bit registers and must be dropped
            default: return is_release ? 24'($urandom) :
                            24'($urandom_range(24'h7FFFFF, 1) | ($urandom_range(1) << 23));
        endcase
    endfunction

    // mix of extremes, levels around the threshold, release-range and wideband samples
    function automatic logic [23:0] rand_sample();
        logic [23:0] m;
        logic [23:0] t;
        t = {1'b0, sb.thr};
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return 24'h800000;
                    1: return 24'h7FFFFF;
                    2: return 24'h000000;
                    default: return 24'hFFFFFF;
                endcase
            end
            1: m = 24'(t + $urandom_range(2) - 1);
            2, 3, 4: m = 24'($urandom_range(t));
            default: return 24'($urandom);
        endcase
        if ($urandom_range(1)) m = -m;
        return m;
    endfunction

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: full scale both ways; negative full scale exceeds the threshold and attacks
        send_pair(24'h000000, 24'h000000);
        send_pair(24'h7FFFFF, 24'h800000);
        send_pair(24'h800000, 24'h000000);
        send_pair(24'hFFFFFF, 24'h000001);
        send_pair(24'h7FFFFF, 24'h7FFFFF);
        send_pair(24'h000001, 24'hFFFFFF);

        // attack then release, peak equal to threshold is not an attack
        drain();
        apply_config(24'h400000, 24'h300000, 24'h100000, 1'b0);
        send_pair(24'h7FFFFF, 24'h000000);
        send_pair(24'h400000, 24'hC00000);
        send_pair(24'h400001, 24'hBFFFFF);
        send_pair(24'h800000, 24'h800000);
        send_pair(24'h000000, 24'h000000);
        send_pair(24'h000000, 24'h000000);
        send_pair(24'h000000, 24'h000000);
        send_pair(24'h123456, 24'h9ABCDE);

        // threshold and ceiling masked to zero, release above unity, spare index
        drain();
        apply_config(24'h800000, 24'h800000, 24'hFFFFFF, 1'b1);
        send_pair(24'h000000, 24'h000000);
        send_pair(24'h000001, 24'h000000);
        send_pair(24'hFFFFFF, 24'hFFFFFF);
        send_pair(24'h000000, 24'h000000);
        send_pair(24'h7FFFFF, 24'h800000);

        // minimum ceiling, unity release
        drain();
        apply_config(24'h7FFFFF, 24'h000001, 24'h800000, 1'b0);
        send_pair(24'h000000, 24'h000000);
        send_pair(24'h7FFFFF, 24'h800000);
        send_pair(24'h400000, 24'h000000);

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin snd_idle_pct = 36; rcv_idle_pct = 68; end
                1: begin snd_idle_pct = 68; rcv_idle_pct = 36; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            for (int k = 0; k < 2; k++) begin
                drain();
                apply_config(pick_level(1'b0), pick_level(1'b0), pick_level(1'b1),
                             1'($urandom_range(1)));
                repeat (215) send_pair(rand_sample(), rand_sample());
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.limited_q.size() != 0)
            sb.report($sformatf("%0d outputs never arrived", sb.limited_q.size()));
        if (sb.errors == 0) begin
            $display("** stereo_peak_limiter: PASSED **");
        end else begin
            $display("** stereo_peak_limiter: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/spl_pkg.sv
hw/rtl/spl_mul.sv
hw/rtl/spl_div.sv
hw/rtl/stereo_peak_limiter.sv
test/stereo_peak_limiter_tb.sv
